/* rtl/smalu_pkg.sv */
// Package for the sign-magnitude ALU: action codes, defaults and the
// control record that travels down the cell chain. No dependencies.
`default_nettype none
package smalu_pkg;

  localparam int MAG_WIDTH_DEFAULT = 63;

  localparam logic [2:0] ACT_ADD = 3'd0;
  localparam logic [2:0] ACT_SUB = 3'd1;
  localparam logic [2:0] ACT_MUL = 3'd2;
  localparam logic [2:0] ACT_DIV = 3'd3;
  localparam logic [2:0] ACT_REM = 3'd4;
  localparam logic [2:0] ACT_NEG = 3'd5;

  typedef struct packed {
    logic [2:0] action;
    logic       a_pos;
    logic       b_pos;
    logic       add_pos;
    logic       add_ovf;
    logic       eq;
    logic       gt;
    logic       lt;
  } smalu_ctl_t;

endpackage
`default_nettype wire

/* rtl/smalu_front.sv */
// Front stage of the sign-magnitude ALU: signed add or subtract and the
// operand comparison, registered. Depends on smalu_pkg.
`default_nettype none
module smalu_front #(
  parameter int W = smalu_pkg::MAG_WIDTH_DEFAULT
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     en,
  input  wire                     in_valid,
  input  wire  [2:0]              action,
  input  wire                     a_positive,
  input  wire  [W-1:0]            a_magnitude,
  input  wire                     b_positive,
  input  wire  [W-1:0]            b_magnitude,
  output logic                    valid,
  output smalu_pkg::smalu_ctl_t   ctl,
  output logic [W-1:0]            a_mag,
  output logic [W-1:0]            b_mag,
  output logic [W-1:0]            add_mag
);
  import smalu_pkg::*;

  logic       b_eff;
  logic       a_gt_b;
  logic [W:0] sum;
  smalu_ctl_t ctl_next;
  logic [W-1:0] add_mag_next;

  always_comb begin
    b_eff  = (action == ACT_SUB) ? ~b_positive : b_positive;
    a_gt_b = a_magnitude > b_magnitude;
    sum    = {1'b0, a_magnitude} + {1'b0, b_magnitude};
    ctl_next.action = action;
    ctl_next.a_pos  = a_positive;
    ctl_next.b_pos  = b_positive;
    ctl_next.add_ovf = 1'b0;
    if (a_positive == b_eff) begin
      ctl_next.add_pos = a_positive;
      ctl_next.add_ovf = sum[W];
      add_mag_next     = sum[W-1:0];
    end else if (a_gt_b) begin
      ctl_next.add_pos = a_positive;
      add_mag_next     = a_magnitude - b_magnitude;
    end else begin
      // Equal magnitudes land here and take the second operand's effective sign.
      ctl_next.add_pos = b_eff;
      add_mag_next     = b_magnitude - a_magnitude;
    end
    ctl_next.eq = (a_positive == b_positive) && (a_magnitude == b_magnitude);
    if (a_positive != b_positive) begin
      ctl_next.gt = a_positive;
      ctl_next.lt = b_positive;
    end else if (a_positive) begin
      ctl_next.gt = a_gt_b;
      ctl_next.lt = a_magnitude < b_magnitude;
    end else begin
      ctl_next.gt = a_magnitude < b_magnitude;
      ctl_next.lt = a_gt_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl     <= ctl_next;
      a_mag   <= a_magnitude;
      b_mag   <= b_magnitude;
      add_mag <= add_mag_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/smalu_cell.sv */
// One cell of the chain: a restoring divide step on one dividend bit and a
// shift-add multiply step on one multiplier bit. Depends on smalu_pkg.
`default_nettype none
module smalu_cell #(
  parameter int W   = smalu_pkg::MAG_WIDTH_DEFAULT,
  parameter int IDX = 0
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     en,
  input  wire                     in_valid,
  input  smalu_pkg::smalu_ctl_t   in_ctl,
  input  wire  [W-1:0]            in_a,
  input  wire  [W-1:0]            in_b,
  input  wire  [W-1:0]            in_add,
  input  wire  [W-1:0]            in_rem,
  input  wire  [W-1:0]            in_quo,
  input  wire  [2*W-1:0]          in_acc,
  output logic                    valid,
  output smalu_pkg::smalu_ctl_t   ctl,
  output logic [W-1:0]            a,
  output logic [W-1:0]            b,
  output logic [W-1:0]            add,
  output logic [W-1:0]            rem,
  output logic [W-1:0]            quo,
  output logic [2*W-1:0]          acc
);
  import smalu_pkg::*;

  logic [W:0]     trial;
  logic [W:0]     diff;
  logic           take;
  logic [2*W-1:0] part;

  always_comb begin
    trial = {in_rem, in_a[W-1-IDX]};
    diff  = trial - {1'b0, in_b};
    take  = trial >= {1'b0, in_b};
    part  = in_b[IDX] ? ({{W{1'b0}}, in_a} << IDX) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl <= in_ctl;
      a   <= in_a;
      b   <= in_b;
      add <= in_add;
      rem <= take ? diff[W-1:0] : trial[W-1:0];
      quo <= {in_quo[W-2:0], take};
      acc <= in_acc + part;
    end
  end

endmodule
`default_nettype wire

/* rtl/sign_magnitude_alu.sv */
// Top level of the sign-magnitude ALU: front stage, cell chain and result
// register. Depends on smalu_pkg, smalu_front and smalu_cell.
//
// Usage: an operation enters on the slave stream (s_tuser is the action,
// s_tdata the two sign-magnitude operands) and its result leaves on the
// master stream (m_tdata holds sign, magnitude and the five flags).
// Each word passes a front stage (add, subtract, compare), a chain of
// MAG_WIDTH cells, each settling one quotient bit and one multiplier bit,
// and a result register. A new word is taken every cycle while results
// are taken; throughput is one word per cycle, set by the
// one-bit-per-cell chain being fully pipelined. When the receiver holds
// m_tready low with a result waiting, the whole chain holds and s_tready
// falls until that result is taken. Reset empties the pipeline; no word
// is pending afterwards.
`default_nettype none
module sign_magnitude_alu #(
  parameter int MAG_WIDTH = smalu_pkg::MAG_WIDTH_DEFAULT,
  localparam int IN_W  = ((2 * MAG_WIDTH + 2 + 7) / 8) * 8,
  localparam int OUT_W = ((MAG_WIDTH + 6 + 7) / 8) * 8
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              s_tvalid,
  output logic             s_tready,
  // a_positive, a_magnitude, b_positive, b_magnitude, zero fill
  input  wire  [IN_W-1:0]  s_tdata,
  // action
  input  wire  [2:0]       s_tuser,
  output logic             m_tvalid,
  input  wire              m_tready,
  // result_positive, result_magnitude, overflow, divide_by_zero,
  // is_equal, is_greater, is_less, zero fill
  output logic [OUT_W-1:0] m_tdata
);
  import smalu_pkg::*;

  localparam int W = MAG_WIDTH;

  logic             en;
  logic             v   [W+1];
  smalu_ctl_t       c   [W+1];
  logic [W-1:0]     am  [W+1];
  logic [W-1:0]     bm  [W+1];
  logic [W-1:0]     ad  [W+1];
  logic [W-1:0]     rm  [W+1];
  logic [W-1:0]     qu  [W+1];
  logic [2*W-1:0]   ac  [W+1];

  logic             r_pos;
  logic [W-1:0]     r_mag;
  logic             r_ovf;
  logic             r_dz;
  smalu_ctl_t       fc;

  assign en       = ~m_tvalid | m_tready;
  assign s_tready = en;

  smalu_front #(.W(W)) u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_tvalid),
    .action(s_tuser),
    .a_positive(s_tdata[0]),
    .a_magnitude(s_tdata[W:1]),
    .b_positive(s_tdata[W+1]),
    .b_magnitude(s_tdata[2*W+1:W+2]),
    .valid(v[0]), .ctl(c[0]), .a_mag(am[0]), .b_mag(bm[0]), .add_mag(ad[0])
  );

  assign rm[0] = '0;
  assign qu[0] = '0;
  assign ac[0] = '0;

  for (genvar i = 0; i < W; i++) begin : g_cell
    smalu_cell #(.W(W), .IDX(i)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(v[i]), .in_ctl(c[i]), .in_a(am[i]), .in_b(bm[i]),
      .in_add(ad[i]), .in_rem(rm[i]), .in_quo(qu[i]), .in_acc(ac[i]),
      .valid(v[i+1]), .ctl(c[i+1]), .a(am[i+1]), .b(bm[i+1]),
      .add(ad[i+1]), .rem(rm[i+1]), .quo(qu[i+1]), .acc(ac[i+1])
    );
  end

  always_comb begin
    fc    = c[W];
    r_pos = 1'b1;
    r_mag = '0;
    r_ovf = 1'b0;
    r_dz  = 1'b0;
    case (fc.action)
      ACT_ADD, ACT_SUB: begin
        r_pos = fc.add_pos;
        r_mag = ad[W];
        r_ovf = fc.add_ovf;
      end
      ACT_MUL: begin
        r_pos = fc.a_pos == fc.b_pos;
        r_mag = ac[W][W-1:0];
        r_ovf = |ac[W][2*W-1:W];
      end
      ACT_DIV: begin
        if (bm[W] == '0) begin
          r_dz = 1'b1;
        end else begin
          r_pos = fc.a_pos == fc.b_pos;
          r_mag = qu[W];
        end
      end
      ACT_REM: begin
        if (bm[W] == '0) begin
          r_dz = 1'b1;
        end else begin
          r_pos = fc.a_pos;
          r_mag = rm[W];
        end
      end
      ACT_NEG: begin
        r_pos = ~fc.a_pos;
        r_mag = am[W];
      end
      default: begin
        r_pos = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= v[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {{(OUT_W - W - 6){1'b0}}, fc.lt, fc.gt, fc.eq, r_dz, r_ovf, r_mag, r_pos};
    end
  end

  a_cmp_onehot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot(m_tdata[W+5:W+3]))
    else $error("compare flags not exactly one");
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[W+2]) |-> (m_tdata[W:1] == '0 && m_tdata[0]))
    else $error("divide by zero result not plus zero");
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[W+1] && m_tdata[W+2]))
    else $error("overflow and divide by zero together");

endmodule
`default_nettype wire
